// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker of the fragment datagram parser.
// Depends on nothing; the user module must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, switched off while the given reset is low.
`define FDP_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same assertion on the usual clk_i / rst_ni pair.
`define FDP_ASSERT(label, prop, msg) \
  `FDP_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/fdp_pkg.sv -----
// Types and constants of the fragment datagram parser.
// Used by the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package fdp_pkg;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_LONG     = 4'd2,
    ST_MAGIC    = 4'd3,
    ST_VERSION  = 4'd4,
    ST_FLAGS    = 4'd5,
    ST_RESERVED = 4'd6,
    ST_FRAGMENT = 4'd7,
    ST_RECORDS  = 4'd8,
    ST_TRUNC    = 4'd9,
    ST_LENGTH   = 4'd10,
    ST_OVERRUN  = 4'd11,
    ST_DUP      = 4'd12,
    ST_TRAILING = 4'd13
  } status_e;

  // Configuration register indexes.
  localparam logic [7:0] CfgMagicWord   = 8'd0;
  localparam logic [7:0] CfgVersion     = 8'd1;
  localparam logic [7:0] CfgMaxDatagram = 8'd2;
  localparam logic [7:0] CfgMaxRecord   = 8'd3;

  // Header layout.
  localparam logic [15:0] HeaderLen = 16'd14;
  localparam logic [3:0] PosMagicHi  = 4'd0;
  localparam logic [3:0] PosMagicLo  = 4'd1;
  localparam logic [3:0] PosVersion  = 4'd2;
  localparam logic [3:0] PosFlags    = 4'd3;
  localparam logic [3:0] PosGenHi    = 4'd4;
  localparam logic [3:0] PosGenLo    = 4'd5;
  localparam logic [3:0] PosSeq3     = 4'd6;
  localparam logic [3:0] PosSeq2     = 4'd7;
  localparam logic [3:0] PosSeq1     = 4'd8;
  localparam logic [3:0] PosSeq0     = 4'd9;
  localparam logic [3:0] PosFragIdx  = 4'd10;
  localparam logic [3:0] PosFragCnt  = 4'd11;
  localparam logic [3:0] PosRecCnt   = 4'd12;

  // Reset values of the configuration registers.
  localparam logic [15:0] RstMagicWord   = 16'd0;
  localparam logic [7:0]  RstVersion     = 8'd1;
  localparam logic [15:0] RstMaxDatagram = 16'd1400;
  localparam logic [15:0] RstMaxRecord   = 16'd1024;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  record_index;
    logic [7:0]  record_key;
    logic [7:0]  payload_byte;
    logic [3:0]  status;
    logic        raw_flag;
    logic [15:0] generation;
    logic [31:0] sequence_res;
    logic [2:0]  fragment_index;
    logic [3:0]  fragment_count;
    logic [4:0]  record_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  reg_index;
    logic [15:0] wr_data;
  } cfg_wr_t;

endpackage

// ----- rtl/fdp_stream_if.sv -----
// Valid/ready channel carrying one payload word per handshake.
// The payload type is set where the channel is instantiated.
`timescale 1ns / 1ps

interface fdp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/fragment_datagram_parser_core.sv -----
// Fragment datagram parser: header checks, record walk and payload forwarding.
// Depends on fdp_pkg and the fdp_stream_if channel interface.
`timescale 1ns / 1ps
//
//   Channel | Dir | Payload     | Word
//   --------+-----+-------------+---------------------------------------------
//   in_i    | in  | in_item_t   | one datagram byte and its last-byte marker
//   out_o   | out | out_item_t  | one payload byte result or one status result
//   cfg_i   | in  | cfg_wr_t    | one register write (index and data)
//
// Every input byte is parsed in the cycle it is accepted, so the block takes one
// byte per clock while input ready is high. A byte yields zero, one or two result
// words, written into a four-entry result queue; the output drains one word per
// clock while out_o.ready is high. Input ready is high while the queue holds two
// words or fewer, so a stalled output stops the input once over two words wait.
// Reset is asynchronous and active low; it resets the parser state, the queue and
// the configuration registers. The seen-key table needs no reset since only entries already written are read.

module fragment_datagram_parser_core #(
  parameter int MAX_RECORDS   = 16,
  parameter int MAX_FRAGMENTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  fdp_stream_if.sink          in_i,
  fdp_stream_if.source        out_o,
  fdp_stream_if.sink          cfg_i
);
  import fdp_pkg::*;

  // Record counters hold up to MAX_RECORDS; the key table index covers entries below it.
  localparam int RecCntW = $clog2(MAX_RECORDS + 1);
  localparam int RecIdxW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam logic [7:0] MaxRecByte  = 8'(MAX_RECORDS);
  localparam logic [7:0] MaxFragByte = 8'(MAX_FRAGMENTS);

  // The result queue holds two words beyond the two that one byte may add.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);
  localparam logic [QCntW-1:0] QReadyLimit = QCntW'(QDepth - 2);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_KEY,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_DONE,
    PH_HALT
  } phase_e;

  // Configuration registers.
  logic [15:0] magic_q;
  logic [7:0]  version_q;
  logic [15:0] max_dg_q;
  logic [15:0] max_rec_q;

  // Parser state.
  phase_e               phase_q, phase_d;
  logic [15:0]          byte_cnt_q, byte_cnt_d;
  logic                 ovs_q, ovs_d;
  logic                 raw_q, raw_d;
  logic [15:0]          gen_q, gen_d;
  logic [31:0]          seq_q, seq_d;
  logic [2:0]           fidx_q, fidx_d;
  logic [3:0]           fcnt_q, fcnt_d;
  logic [RecCntW-1:0]   rec_total_q, rec_total_d;
  logic [RecCntW-1:0]   cur_rec_q, cur_rec_d;
  logic [7:0]           cur_key_q, cur_key_d;
  logic [15:0]          len_acc_q, len_acc_d;
  logic [15:0]          pay_left_q, pay_left_d;
  status_e              err_q, err_d;

  logic [7:0] seen_keys [MAX_RECORDS];
  logic       seen_we;

  // Result queue.
  out_item_t          fifo_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q;

  logic        in_fire, out_fire, cfg_fire;
  logic [7:0]  b;
  logic        is_last;
  logic        parse_en;
  logic        dup;
  logic        fwd;
  logic [15:0] rec_len;
  logic [15:0] left_dec;
  logic [RecCntW-1:0] rec_inc;
  status_e     end_st;
  out_item_t   pay_item, stat_item, push0, push1;
  logic [1:0]  push_n;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign b       = in_i.payload.data_byte;
  assign is_last = in_i.payload.last_byte;

  // Register writes are taken at once.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= RstMagicWord;
      version_q <= RstVersion;
      max_dg_q  <= RstMaxDatagram;
      max_rec_q <= RstMaxRecord;
    end else if (cfg_fire) begin
      case (cfg_i.payload.reg_index)
        CfgMagicWord:   magic_q   <= cfg_i.payload.wr_data;
        CfgVersion:     version_q <= cfg_i.payload.wr_data[7:0];
        CfgMaxDatagram: max_dg_q  <= cfg_i.payload.wr_data;
        CfgMaxRecord:   max_rec_q <= cfg_i.payload.wr_data;
        default: ;
      endcase
    end
  end

  // A key is a duplicate when it matches any record already started; all stored
  // keys are compared in parallel.
  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < MAX_RECORDS; i++) begin
      if ((RecCntW'(i) < cur_rec_q) && (seen_keys[i] == b)) begin
        dup = 1'b1;
      end
    end
  end

  // Bytes past the length limit, or past the 16-bit counter, are not parsed.
  assign parse_en = !ovs_q && (byte_cnt_q < max_dg_q);
  assign rec_len  = {len_acc_q[15:8], b};
  assign left_dec = pay_left_q - 16'd1;
  assign rec_inc  = cur_rec_q + RecCntW'(1);

  // Next parser state for the byte on the input. The clear at the end of a
  // datagram is applied in the clocked block, after the status is formed.
  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = byte_cnt_q;
    ovs_d       = ovs_q;
    raw_d       = raw_q;
    gen_d       = gen_q;
    seq_d       = seq_q;
    fidx_d      = fidx_q;
    fcnt_d      = fcnt_q;
    rec_total_d = rec_total_q;
    cur_rec_d   = cur_rec_q;
    cur_key_d   = cur_key_q;
    len_acc_d   = len_acc_q;
    pay_left_d  = pay_left_q;
    err_d       = err_q;
    seen_we     = 1'b0;
    fwd         = 1'b0;
    if (in_fire) begin
      if (parse_en) begin
        // Parsing only runs while no error is recorded, so a failure simply
        // records its own code and halts.
        case (phase_q)
          PH_HEADER: begin
            case (byte_cnt_q[3:0])
              PosMagicHi: begin
                if (b != magic_q[15:8]) begin
                  err_d = ST_MAGIC; phase_d = PH_HALT;
                end
              end
              PosMagicLo: begin
                if (b != magic_q[7:0]) begin
                  err_d = ST_MAGIC; phase_d = PH_HALT;
                end
              end
              PosVersion: begin
                if (b != version_q) begin
                  err_d = ST_VERSION; phase_d = PH_HALT;
                end
              end
              PosFlags: begin
                if (b[7:1] != 7'd0) begin
                  err_d = ST_FLAGS; phase_d = PH_HALT;
                end else begin
                  raw_d = b[0];
                end
              end
              PosGenHi:   gen_d[15:8]  = b;
              PosGenLo:   gen_d[7:0]   = b;
              PosSeq3:    seq_d[31:24] = b;
              PosSeq2:    seq_d[23:16] = b;
              PosSeq1:    seq_d[15:8]  = b;
              PosSeq0:    seq_d[7:0]   = b;
              PosFragIdx: len_acc_d    = {8'd0, b};
              PosFragCnt: begin
                // The fragment index byte waits in the length accumulator.
                if ((b == 8'd0) || (b > MaxFragByte) || (len_acc_q[7:0] >= b)) begin
                  err_d = ST_FRAGMENT; phase_d = PH_HALT;
                end else begin
                  fidx_d = len_acc_q[2:0];
                  fcnt_d = b[3:0];
                end
                len_acc_d = 16'd0;
              end
              PosRecCnt: begin
                if ((b == 8'd0) || (b > MaxRecByte)) begin
                  err_d = ST_RECORDS; phase_d = PH_HALT;
                end else begin
                  rec_total_d = RecCntW'(b);
                end
              end
              default: begin
                // Reserved byte, the last one of the header.
                if (b != 8'd0) begin
                  err_d = ST_RESERVED; phase_d = PH_HALT;
                end else begin
                  phase_d = PH_KEY;
                end
              end
            endcase
          end
          PH_KEY: begin
            if (dup) begin
              err_d = ST_DUP; phase_d = PH_HALT;
            end else begin
              seen_we   = (cur_rec_q < RecCntW'(MAX_RECORDS));
              cur_key_d = b;
              phase_d   = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            len_acc_d = {b, 8'd0};
            phase_d   = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_acc_d = rec_len;
            if ((rec_len == 16'd0) || (rec_len > max_rec_q)) begin
              err_d = ST_LENGTH; phase_d = PH_HALT;
            end else begin
              pay_left_d = rec_len;
              phase_d    = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            fwd        = 1'b1;
            pay_left_d = left_dec;
            if (left_dec == 16'd0) begin
              cur_rec_d = rec_inc;
              phase_d   = (rec_inc >= rec_total_q) ? PH_DONE : PH_KEY;
            end
          end
          PH_DONE: begin
            err_d = ST_TRAILING; phase_d = PH_HALT;
          end
          default: ;
        endcase
      end
      // The counter saturates; the oversize bit remembers the overflow.
      if (byte_cnt_q == 16'hFFFF) begin
        ovs_d = 1'b1;
      end else begin
        byte_cnt_d = byte_cnt_q + 16'd1;
      end
    end
  end

  // End status: length errors first, then the recorded error, then where the
  // datagram stopped.
  always_comb begin
    if (byte_cnt_d < HeaderLen) begin
      end_st = ST_SHORT;
    end else if (ovs_d || (byte_cnt_d > max_dg_q)) begin
      end_st = ST_LONG;
    end else if (err_d != ST_OK) begin
      end_st = err_d;
    end else begin
      case (phase_d)
        PH_PAYLOAD: end_st = ST_OVERRUN;
        PH_DONE:    end_st = ST_OK;
        default:    end_st = ST_TRUNC;
      endcase
    end
  end

  always_comb begin
    pay_item              = '0;
    pay_item.kind         = 1'b0;
    pay_item.record_index = 4'(cur_rec_q);
    pay_item.record_key   = cur_key_q;
    pay_item.payload_byte = b;
    pay_item.last         = !is_last;

    stat_item        = '0;
    stat_item.kind   = 1'b1;
    stat_item.status = end_st;
    stat_item.last   = 1'b1;
    if (end_st == ST_OK) begin
      stat_item.raw_flag       = raw_d;
      stat_item.generation     = gen_d;
      stat_item.sequence_res   = seq_d;
      stat_item.fragment_index = fidx_d;
      stat_item.fragment_count = fcnt_d;
      stat_item.record_count   = 5'(rec_total_d);
    end
  end

  // A payload word goes ahead of the status word when one byte makes both.
  always_comb begin
    push0  = fwd ? pay_item : stat_item;
    push1  = stat_item;
    push_n = 2'd0;
    if (in_fire) begin
      push_n = {1'b0, fwd} + {1'b0, is_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      byte_cnt_q  <= '0;
      ovs_q       <= 1'b0;
      raw_q       <= 1'b0;
      gen_q       <= '0;
      seq_q       <= '0;
      fidx_q      <= '0;
      fcnt_q      <= '0;
      rec_total_q <= '0;
      cur_rec_q   <= '0;
      cur_key_q   <= '0;
      len_acc_q   <= '0;
      pay_left_q  <= '0;
      err_q       <= ST_OK;
    end else if (in_fire && is_last) begin
      // The last byte closes the datagram; start clean for the next one.
      phase_q     <= PH_HEADER;
      byte_cnt_q  <= '0;
      ovs_q       <= 1'b0;
      raw_q       <= 1'b0;
      gen_q       <= '0;
      seq_q       <= '0;
      fidx_q      <= '0;
      fcnt_q      <= '0;
      rec_total_q <= '0;
      cur_rec_q   <= '0;
      cur_key_q   <= '0;
      len_acc_q   <= '0;
      pay_left_q  <= '0;
      err_q       <= ST_OK;
    end else begin
      phase_q     <= phase_d;
      byte_cnt_q  <= byte_cnt_d;
      ovs_q       <= ovs_d;
      raw_q       <= raw_d;
      gen_q       <= gen_d;
      seq_q       <= seq_d;
      fidx_q      <= fidx_d;
      fcnt_q      <= fcnt_d;
      rec_total_q <= rec_total_d;
      cur_rec_q   <= cur_rec_d;
      cur_key_q   <= cur_key_d;
      len_acc_q   <= len_acc_d;
      pay_left_q  <= pay_left_d;
      err_q       <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_keys[cur_rec_q[RecIdxW-1:0]] <= b;
    end
  end

  // Result queue storage and pointers.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= push0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + QPtrW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(push_n) - QCntW'(out_fire);
    end
  end

  assign in_i.ready    = (cnt_q <= QReadyLimit);
  assign out_o.valid   = (cnt_q != '0);
  assign out_o.payload = fifo_q[rd_ptr_q];

endmodule

// ----- rtl/fdp_checker.sv -----
// Port-level checks on the result channel of the fragment datagram parser.
// Depends on fdp_pkg and assert_macros.svh; bound to the top level below.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input fdp_pkg::out_item_t  out_item_i
);
  import fdp_pkg::*;

  // A result word once offered stays offered until taken.
  `FDP_ASSERT(a_out_valid_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result word withdrawn")

  // A status word always closes the results of its byte.
  `FDP_ASSERT(a_status_last, out_valid_i && out_item_i.kind |-> out_item_i.last, "status word not last")

  // A failed datagram reports no header fields.
  `FDP_ASSERT(a_err_no_header, out_valid_i && out_item_i.kind && (out_item_i.status != ST_OK) |-> (out_item_i.generation == 16'd0) && (out_item_i.sequence_res == 32'd0) && !out_item_i.raw_flag && (out_item_i.record_count == 5'd0), "header fields on error status")

  // A payload word carries no status or header content.
  `FDP_ASSERT(a_payload_clean, out_valid_i && !out_item_i.kind |-> (out_item_i.status == ST_OK) && (out_item_i.generation == 16'd0) && (out_item_i.fragment_count == 4'd0), "status bits on payload word")

endmodule

bind fragment_datagram_parser_core fdp_checker u_fdp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);
